// ===== design/assert_macros.svh =====
// assertion macros shared by the blur design files
// no dependencies; included by modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define GBLUR_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// condition must never be seen outside reset
`define GBLUR_ASSERT_NEVER(name, clk, rstn, cond, msg) \
  `GBLUR_ASSERT(name, clk, rstn, !(cond), msg)

`endif

// ===== design/gblur_pkg.sv =====
// shared types and constants of the 3x3 blur stream
// no dependencies; used by every other design file but assert_macros.svh
`default_nettype none

package gblur_pkg;

  localparam int unsigned PixW       = 8;
  localparam int unsigned ColW       = 12;
  localparam int unsigned RowW       = 13;
  localparam int unsigned SumW       = 12;
  localparam int unsigned DivShift   = 4;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PaddrW     = 3;
  localparam int unsigned RegIdxBit  = 2;
  localparam int unsigned DataW      = 32;

  localparam logic [ColW-1:0] WidthReset  = 12'd1920;
  localparam logic [RowW-1:0] HeightReset = 13'd2520;

  typedef enum logic {
    OpPixel = 1'b0,
    OpDrain = 1'b1
  } op_e;

  typedef enum logic {
    RegWidth  = 1'b0,
    RegHeight = 1'b1
  } reg_e;

  typedef struct packed {
    logic            operation;
    logic [PixW-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [PixW-1:0] filtered_pixel;
    logic            last_of_frame;
    logic            frame_changed;
  } out_item_t;

  // frame settings and restart strobe from the register block
  typedef struct packed {
    logic            restart;
    logic [ColW-1:0] width_m1;
    logic [RowW-1:0] height_m1;
  } frame_ctl_t;

  // classified item passed from front to back
  typedef struct packed {
    logic [ColW-1:0] col;
    logic [PixW-1:0] incoming;
    logic            emit;
    logic            top;
    logic            bottom;
    logic            left;
    logic            right;
    logic            last;
  } entry_t;

endpackage

`default_nettype wire

// ===== design/gblur_stream_if.sv =====
// valid/ready stream interfaces for the blur input and output channels
// depends on gblur_pkg for the payload types
`default_nettype none

interface gblur_in_if ();
  logic                 valid;
  logic                 ready;
  gblur_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gblur_out_if ();
  logic                 valid;
  logic                 ready;
  gblur_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/gaussian_blur_3x3_stream_unit.sv =====
// top level of the 3x3 blur stream: register block, front end, queue, back end
// depends on gblur_pkg, gblur_stream_if, gblur_front, gblur_queue, gblur_back
`default_nettype none

// Streaming 3x3 Gaussian blur (1 2 1 / 2 4 2 / 1 2 1, divided by 16, truncated) over 8-bit
// grey pixels in raster order. One input transfer is taken per clock cycle in steady state;
// unless the output stalls; the result for a pixel leaves with the input transfer that
// arrives width+1 items later, so after each frame the host sends width+1 drain items.
// From input transfer to output valid there are four register stages (queue, line-store
// read, window, output register). The rate is set by the two MAX_WIDTH x 8 line stores,
// each read at one address and written at one address per cycle. The line stores are not
// cleared after reset. A write to image_width (byte address 0) or image_height (byte
// address 4) restarts the frame and may only be done while no results are pending.
module gaussian_blur_3x3_stream_unit #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gblur_pkg::PaddrW-1:0] paddr,
  input  logic [gblur_pkg::DataW-1:0]  pwdata,
  output logic [gblur_pkg::DataW-1:0]  prdata,
  output logic                         pready,
  gblur_in_if.sink                     in_i,
  gblur_out_if.source                  out_o
);

  logic [gblur_pkg::ColW-1:0] width_q, width_eff;
  logic [gblur_pkg::RowW-1:0] height_q;
  logic                       cfg_we;
  gblur_pkg::reg_e            reg_sel;
  gblur_pkg::frame_ctl_t      ctl;

  logic                       q_push_valid, q_push_ready;
  logic                       q_pop_valid, q_pop_ready;
  gblur_pkg::entry_t          q_push_data, q_pop_data;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_sel = gblur_pkg::reg_e'(paddr[gblur_pkg::RegIdxBit]);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gblur_pkg::WidthReset;
      height_q <= gblur_pkg::HeightReset;
    end else if (cfg_we) begin
      case (reg_sel)
        gblur_pkg::RegWidth: begin
          width_q <= pwdata[gblur_pkg::ColW-1:0];
        end
        gblur_pkg::RegHeight: begin
          height_q <= pwdata[gblur_pkg::RowW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_sel)
      gblur_pkg::RegWidth:  prdata = gblur_pkg::DataW'(width_q);
      gblur_pkg::RegHeight: prdata = gblur_pkg::DataW'(height_q);
      default:              prdata = '0;
    endcase
  end

  // effective frame size: zero reads as one, width saturates at the line store depth
  always_comb begin
    if (width_q == '0) begin
      width_eff = gblur_pkg::ColW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      width_eff = gblur_pkg::ColW'(MAX_WIDTH);
    end else begin
      width_eff = width_q;
    end
  end

  assign ctl.restart   = cfg_we;
  assign ctl.width_m1  = width_eff - gblur_pkg::ColW'(1);
  assign ctl.height_m1 = (height_q == '0) ? '0 : height_q - gblur_pkg::RowW'(1);

  gblur_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .in_i         (in_i),
    .push_valid_o (q_push_valid),
    .push_ready_i (q_push_ready),
    .push_data_o  (q_push_data)
  );

  gblur_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_data_i  (q_push_data),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_data_o   (q_pop_data)
  );

  gblur_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .pop_valid_i (q_pop_valid),
    .pop_ready_o (q_pop_ready),
    .pop_data_i  (q_pop_data),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ===== design/gblur_queue.sv =====
// two-entry queue decoupling the classifier from the filter datapath
// depends on gblur_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module gblur_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  gblur_pkg::entry_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output gblur_pkg::entry_t pop_data_o
);

  localparam int unsigned PtrW = $clog2(gblur_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(gblur_pkg::QueueDepth + 1);

  gblur_pkg::entry_t slot_q [gblur_pkg::QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != CntW'(gblur_pkg::QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  `GBLUR_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(gblur_pkg::QueueDepth), "queue count above depth")
  `GBLUR_ASSERT(a_count_up, clk_i, rst_ni, push && !pop |=> count_q == $past(count_q) + CntW'(1), "queue count missed a push")
  `GBLUR_ASSERT(a_count_down, clk_i, rst_ni, pop && !push |=> count_q == $past(count_q) - CntW'(1), "queue count missed a pop")

endmodule

`default_nettype wire

// ===== design/gblur_front.sv =====
// front end: accepts input transfers, tracks raster and output positions,
// and tags each item with border and end-of-frame flags; depends on gblur_pkg and gblur_stream_if
`default_nettype none

module gblur_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gblur_pkg::frame_ctl_t ctl_i,
  gblur_in_if.sink              in_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output gblur_pkg::entry_t     push_data_o
);

  localparam logic [1:0] RowsFull = 2'd2;

  logic [gblur_pkg::ColW-1:0] col_q, ocol_q;
  logic [gblur_pkg::RowW-1:0] orow_q;
  logic [1:0]                 rows_q;
  logic                       accept, emit, last;
  logic                       col_end, ocol_end, orow_end;

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign accept       = in_i.valid && push_ready_i;

  // results start once the window has seen one row plus one pixel
  assign emit     = (rows_q == RowsFull) || (rows_q == 2'd1 && col_q != '0);
  assign col_end  = (col_q == ctl_i.width_m1);
  assign ocol_end = (ocol_q == ctl_i.width_m1);
  assign orow_end = (orow_q == ctl_i.height_m1);
  assign last     = emit && ocol_end && orow_end;

  // classified item
  always_comb begin
    push_data_o.col      = col_q;
    push_data_o.incoming = (in_i.data.operation == gblur_pkg::OpDrain)
                           ? '0 : in_i.data.pixel;
    push_data_o.emit     = emit;
    push_data_o.top      = (orow_q == '0);
    push_data_o.bottom   = orow_end;
    push_data_o.left     = (ocol_q == '0);
    push_data_o.right    = ocol_end;
    push_data_o.last     = last;
  end

  // input and output position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      rows_q <= '0;
      ocol_q <= '0;
      orow_q <= '0;
    end else if (ctl_i.restart || (accept && last)) begin
      col_q  <= '0;
      rows_q <= '0;
      ocol_q <= '0;
      orow_q <= '0;
    end else if (accept) begin
      col_q <= col_end ? '0 : col_q + gblur_pkg::ColW'(1);
      if (col_end && rows_q != RowsFull) begin
        rows_q <= rows_q + 2'd1;
      end
      if (emit) begin
        ocol_q <= ocol_end ? '0 : ocol_q + gblur_pkg::ColW'(1);
        if (ocol_end) begin
          orow_q <= orow_q + gblur_pkg::RowW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/gblur_back.sv =====
// back end: line stores, 3x3 window, weighted sum and output register
// depends on gblur_pkg, gblur_stream_if and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module gblur_back #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gblur_pkg::frame_ctl_t ctl_i,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  gblur_pkg::entry_t     pop_data_i,
  gblur_out_if.source           out_o
);

  localparam int unsigned AW   = $clog2(MAX_WIDTH);
  localparam int unsigned PixW = gblur_pkg::PixW;
  localparam int unsigned SumW = gblur_pkg::SumW;

  logic [PixW-1:0] upper_mem  [MAX_WIDTH];
  logic [PixW-1:0] middle_mem [MAX_WIDTH];

  logic                 b1_valid_q, b2_valid_q, out_valid_q, seen_q;
  gblur_pkg::entry_t    b1_q, b2_q;
  gblur_pkg::out_item_t out_q;
  logic [PixW-1:0]      up_rd_q, mid_rd_q;
  logic [PixW-1:0]      win_q    [9];
  logic [PixW-1:0]      win_base [9];
  logic [PixW-1:0]      sel      [9];
  logic [AW-1:0]        a_pop, a_b1;
  logic                 pop, b1_adv, b2_fire, out_free, load, fwd, diff;
  logic [SumW-1:0]      sum;
  logic [PixW-1:0]      result;

  // pipeline handshakes
  assign out_free    = !out_valid_q || out_o.ready;
  assign b2_fire     = b2_valid_q && (!b2_q.emit || out_free);
  assign b1_adv      = b1_valid_q && (!b2_valid_q || b2_fire);
  assign pop_ready_o = !b1_valid_q || b1_adv;
  assign pop         = pop_valid_i && pop_ready_o;
  assign load        = b2_fire && b2_q.emit;

  assign a_pop = AW'(pop_data_i.col);
  assign a_b1  = AW'(b1_q.col);
  // single-column frames read the entry that is being written this cycle
  assign fwd   = b1_adv && (a_b1 == a_pop);

  // line store write, registered read and stage payloads
  always_ff @(posedge clk_i) begin
    if (b1_adv) begin
      upper_mem[a_b1]  <= mid_rd_q;
      middle_mem[a_b1] <= b1_q.incoming;
      b2_q             <= b1_q;
    end
    if (pop) begin
      b1_q <= pop_data_i;
      if (fwd) begin
        up_rd_q  <= mid_rd_q;
        mid_rd_q <= b1_q.incoming;
      end else begin
        up_rd_q  <= upper_mem[a_pop];
        mid_rd_q <= middle_mem[a_pop];
      end
    end
  end

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
      b2_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        b1_valid_q <= 1'b1;
      end else if (b1_adv) begin
        b1_valid_q <= 1'b0;
      end
      if (b1_adv) begin
        b2_valid_q <= 1'b1;
      end else if (b2_fire) begin
        b2_valid_q <= 1'b0;
      end
    end
  end

  // the window restarts empty after the final pixel of a frame
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      win_base[k] = (b2_valid_q && b2_q.last) ? '0 : win_q[k];
    end
  end

  // window shift: new column enters on the right
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else if (ctl_i.restart) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else if (b1_adv) begin
      win_q[0] <= win_base[1];
      win_q[1] <= win_base[2];
      win_q[2] <= up_rd_q;
      win_q[3] <= win_base[4];
      win_q[4] <= win_base[5];
      win_q[5] <= mid_rd_q;
      win_q[6] <= win_base[7];
      win_q[7] <= win_base[8];
      win_q[8] <= b1_q.incoming;
    end else if (b2_fire && b2_q.last) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end
  end

  // neighbors outside the image take the centre value
  always_comb begin
    logic outside;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        outside = (r == 0 && b2_q.top) || (r == 2 && b2_q.bottom) ||
                  (c == 0 && b2_q.left) || (c == 2 && b2_q.right);
        sel[r*3+c] = outside ? win_q[4] : win_q[r*3+c];
      end
    end
  end

  // weights 1 2 1 / 2 4 2 / 1 2 1, then divide by 16
  assign sum = SumW'(sel[0]) + (SumW'(sel[1]) << 1) + SumW'(sel[2])
             + (SumW'(sel[3]) << 1) + (SumW'(sel[4]) << 2) + (SumW'(sel[5]) << 1)
             + SumW'(sel[6]) + (SumW'(sel[7]) << 1) + SumW'(sel[8]);
  assign result = sum[SumW-1:gblur_pkg::DivShift];
  assign diff   = (result != win_q[4]);

  // output register and frame change flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      seen_q      <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (ctl_i.restart) begin
        seen_q <= 1'b0;
      end else if (load) begin
        seen_q <= b2_q.last ? 1'b0 : (seen_q | diff);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.filtered_pixel <= result;
      out_q.last_of_frame  <= b2_q.last;
      out_q.frame_changed  <= b2_q.last && (seen_q || diff);
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  `GBLUR_ASSERT(a_last_has_result, clk_i, rst_ni, b2_valid_q && b2_q.last |-> b2_q.emit, "end of frame flagged on an item with no result")
  `GBLUR_ASSERT(a_hold_on_stall, clk_i, rst_ni, out_valid_q && !out_o.ready && b2_valid_q && b2_q.emit |-> !b1_adv, "window shifted under a stalled result")
  `GBLUR_ASSERT(a_window_cleared, clk_i, rst_ni, b2_fire && b2_q.last && !b1_adv |=> win_q[4] == '0 && win_q[8] == '0 && win_q[0] == '0, "window not cleared after end of frame")

endmodule

`default_nettype wire

// ===== sim/gaussian_blur_3x3_stream_unit_test.sv =====
`timescale 1ns / 100ps
// self-checking bench for the 3x3 blur stream unit: a directed table, then random frames
// depends on gblur_pkg, the gblur_in_if / gblur_out_if interfaces and the blur design files

module gaussian_blur_3x3_stream_unit_test;
  import gblur_pkg::*;

  localparam int unsigned     MaxWidth     = 2048;
  localparam int unsigned     SettleCycles = 16;
  localparam int unsigned     RandomItems  = 1080;
  localparam int unsigned     LongGap      = 20;
  localparam longint unsigned CycleLimit   = 4_000_000;
  localparam out_item_t       NoWant       = '0;

  typedef enum logic [1:0] {
    RowItem,
    RowWrite,
    RowRead
  } row_kind_e;

  typedef enum logic [1:0] {
    FrameClean,
    FrameFlat,
    FrameNoise,
    FrameCut
  } frame_style_e;

  // one line of the directed table; value is write data or expected readback
  typedef struct {
    row_kind_e        kind;
    reg_e             regsel;
    logic [DataW-1:0] value;
    op_e              op;
    logic [PixW-1:0]  pixel;
    bit               typed;
    out_item_t        want;
  } plan_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  gblur_in_if  pix_ch ();
  gblur_out_if blur_ch ();

  gaussian_blur_3x3_stream_unit #(
    .MAX_WIDTH(MaxWidth)
  ) dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .in_i (pix_ch),
    .out_o(blur_ch)
  );

  always #1 clk_i = ~clk_i;

  // blur predictor state
  logic [ColW-1:0] cfg_width;
  logic [RowW-1:0] cfg_height;
  logic [PixW-1:0] line_above [MaxWidth];
  logic [PixW-1:0] line_mid [MaxWidth];
  logic [PixW-1:0] win_px [9];
  int unsigned     in_col;
  int unsigned     in_row;
  int unsigned     out_cnt;
  bit              seen_change;

  out_item_t   pending_blur [$];
  int unsigned blur_errors = 0;
  int unsigned reg_errors = 0;
  bit          send_burst = 1'b0;

  function automatic int unsigned cols_used();
    if (cfg_width == 0) return 1;
    if (cfg_width > MaxWidth) return MaxWidth;
    return cfg_width;
  endfunction

  function automatic int unsigned rows_used();
    return (cfg_height == 0) ? 1 : cfg_height;
  endfunction

  function automatic void clear_frame_state();
    foreach (win_px[i]) win_px[i] = '0;
    in_col      = 0;
    in_row      = 0;
    out_cnt     = 0;
    seen_change = 1'b0;
  endfunction

  // advance the window by one transfer; returns 1 when a blurred pixel comes out
  function automatic bit blur_predict(input op_e op, input logic [PixW-1:0] pix,
                                      output out_item_t res);
    int unsigned     w;
    int unsigned     h;
    int unsigned     slot;
    int unsigned     item;
    int unsigned     crow;
    int unsigned     ccol;
    int unsigned     sum;
    int unsigned     centre;
    logic [PixW-1:0] incoming;
    logic [PixW-1:0] blurred;
    bit              hit;
    w        = cols_used();
    h        = rows_used();
    slot     = in_col % MaxWidth;
    incoming = (op == OpDrain) ? '0 : pix;
    item     = in_row * w + in_col;
    res      = '0;

    // slide left, new column from the two line stores and the incoming pixel
    for (int r = 0; r < 3; r++) begin
      win_px[r*3]   = win_px[r*3+1];
      win_px[r*3+1] = win_px[r*3+2];
    end
    win_px[2]        = line_above[slot];
    win_px[5]        = line_mid[slot];
    win_px[8]        = incoming;
    line_above[slot] = line_mid[slot];
    line_mid[slot]   = incoming;

    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (item < w + 1) return 1'b0;

    // weighted sum, neighbors outside the image take the centre value
    crow   = out_cnt / w;
    ccol   = out_cnt % w;
    centre = win_px[4];
    sum    = 0;
    for (int k = 0; k < 9; k++) begin
      hit = (k / 3 != 0 || crow > 0) && (k / 3 != 2 || crow + 1 < h) &&
            (k % 3 != 0 || ccol > 0) && (k % 3 != 2 || ccol + 1 < w);
      sum += ((k / 3 == 1) ? 2 : 1) * ((k % 3 == 1) ? 2 : 1) * (hit ? win_px[k] : centre);
    end
    blurred            = PixW'(sum >> DivShift);
    res.filtered_pixel = blurred;

    if (out_cnt + 1 >= w * h) begin
      res.last_of_frame = 1'b1;
      res.frame_changed = seen_change | (blurred != centre);
      clear_frame_state();
    end else begin
      seen_change |= (blurred != centre);
      out_cnt++;
    end
    return 1'b1;
  endfunction

  function automatic int unsigned idle_len(bit burst);
    int unsigned r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, LongGap);
  endfunction

  function automatic logic [PixW-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PixW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic plan_row_t mk_row(row_kind_e kind, reg_e regsel, logic [DataW-1:0] value,
                                       op_e op, logic [PixW-1:0] pix, bit typed,
                                       out_item_t want);
    return '{kind, regsel, value, op, pix, typed, want};
  endfunction

  // one pixel-side transfer; valid stays up when the next one follows at once
  task automatic send_transfer(op_e op, logic [PixW-1:0] pix, bit typed, out_item_t want);
    int unsigned gap;
    in_item_t    it;
    out_item_t   res;
    gap = idle_len(send_burst);
    if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
    it.operation = op;
    it.pixel     = pix;
    if (gap != 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.data  <= it;
    do @(posedge clk_i); while (!pix_ch.ready);
    if (blur_predict(op, pix, res)) pending_blur.push_back(typed ? want : res);
  endtask

  // wait for every pending result, then let the pipeline empty
  task automatic settle_block();
    pix_ch.valid <= 1'b0;
    while (pending_blur.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // register write with random bits above the field
  task automatic cfg_write(reg_e r, logic [DataW-1:0] val);
    logic [DataW-1:0] word;
    settle_block();
    word = $urandom;
    if (r == RegWidth) word[ColW-1:0] = val[ColW-1:0];
    else word[RowW-1:0] = val[RowW-1:0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (r == RegWidth) cfg_width = word[ColW-1:0];
    else cfg_height = word[RowW-1:0];
    clear_frame_state();
  endtask

  task automatic cfg_read(reg_e r, logic [DataW-1:0] want);
    settle_block();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {r, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      $error("%s: expected %0d, got %0d", r.name(), want, prdata);
      reg_errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // one frame at the current size; a cut frame stops early
  task automatic stream_frame(frame_style_e style, inout int unsigned sent);
    int unsigned     w;
    int unsigned     pixels;
    int unsigned     total;
    logic [PixW-1:0] flat;
    op_e             op;
    w      = cols_used();
    pixels = w * rows_used();
    total  = pixels + w + 1;
    flat   = rand_pixel();
    if (style == FrameCut) total = $urandom_range(1, total - 1);
    for (int unsigned i = 0; i < total; i++) begin
      if (style == FrameNoise) op = ($urandom_range(0, 1) != 0) ? OpDrain : OpPixel;
      else op = (i < pixels) ? OpPixel : OpDrain;
      send_transfer(op, (style == FrameFlat) ? flat : rand_pixel(), 1'b0, NoWant);
    end
    sent += total;
  endtask

  // result side: random stalls, compare each transfer with the oldest prediction
  initial begin : receiver
    int unsigned stall;
    bit          recv_burst;
    out_item_t   seen;
    out_item_t   want;
    stall         = 0;
    recv_burst    = 1'b0;
    blur_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && blur_ch.valid && blur_ch.ready) begin
        seen = blur_ch.data;
        if (pending_blur.size() == 0) begin
          $error("unexpected result: filtered_pixel %0d", seen.filtered_pixel);
          blur_errors++;
        end else begin
          want = pending_blur.pop_front();
          if (seen.filtered_pixel !== want.filtered_pixel) begin
            $error("filtered_pixel: expected %0d, got %0d",
                   want.filtered_pixel, seen.filtered_pixel);
            blur_errors++;
          end
          if (seen.last_of_frame !== want.last_of_frame) begin
            $error("last_of_frame: expected %0d, got %0d",
                   want.last_of_frame, seen.last_of_frame);
            blur_errors++;
          end
          if (seen.frame_changed !== want.frame_changed) begin
            $error("frame_changed: expected %0d, got %0d",
                   want.frame_changed, seen.frame_changed);
            blur_errors++;
          end
        end
      end
      if (stall != 0) begin
        blur_ch.ready <= 1'b0;
        stall--;
      end else begin
        blur_ch.ready <= 1'b1;
        if ($urandom_range(0, 49) == 0) recv_burst = !recv_burst;
        if (!recv_burst && $urandom_range(0, 3) == 0) stall = idle_len(1'b0);
      end
    end
  end

  // run limit
  initial begin : watchdog
    longint unsigned cycles;
    cycles = 0;
    while (cycles <= CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("** gaussian_blur_3x3_stream_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    plan_row_t    dir_plan [$];
    int unsigned  sent;
    int unsigned  w_pick;
    int unsigned  h_pick;
    int unsigned  style_pick;
    frame_style_e style;

    rst_ni       <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    pix_ch.valid <= 1'b0;
    pix_ch.data  <= '0;

    cfg_width  = WidthReset;
    cfg_height = HeightReset;
    foreach (line_above[i]) begin
      line_above[i] = '0;
      line_mid[i]   = '0;
    end
    clear_frame_state();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values and full-width readback
    dir_plan.push_back(mk_row(RowRead,  RegWidth,  32'(WidthReset),  OpPixel, 8'h00, 1'b1, NoWant));
    dir_plan.push_back(mk_row(RowRead,  RegHeight, 32'(HeightReset), OpPixel, 8'h00, 1'b1, NoWant));
    dir_plan.push_back(mk_row(RowWrite, RegWidth,  32'd4095, OpPixel, 8'h00, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowRead,  RegWidth,  32'd4095, OpPixel, 8'h00, 1'b1, NoWant));
    dir_plan.push_back(mk_row(RowWrite, RegHeight, 32'd8191, OpPixel, 8'h00, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowRead,  RegHeight, 32'd8191, OpPixel, 8'h00, 1'b1, NoWant));
    // single-pixel frames: the blur of a lone pixel is the pixel itself
    dir_plan.push_back(mk_row(RowWrite, RegWidth,  32'd1, OpPixel, 8'h00, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowWrite, RegHeight, 32'd1, OpPixel, 8'h00, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowItem, RegWidth, '0, OpPixel, 8'hFF, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowItem, RegWidth, '0, OpDrain, 8'h00, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowItem, RegWidth, '0, OpDrain, 8'h3C, 1'b1,
                              out_item_t'{8'hFF, 1'b1, 1'b0}));
    // pixel transfer during the drain part only flushes
    dir_plan.push_back(mk_row(RowItem, RegWidth, '0, OpPixel, 8'h5A, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowItem, RegWidth, '0, OpPixel, 8'hA5, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowItem, RegWidth, '0, OpDrain, 8'h00, 1'b1,
                              out_item_t'{8'h5A, 1'b1, 1'b0}));
    // drain in the pixel part stands for a black pixel
    dir_plan.push_back(mk_row(RowItem, RegWidth, '0, OpDrain, 8'hC3, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowItem, RegWidth, '0, OpDrain, 8'hFF, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowItem, RegWidth, '0, OpDrain, 8'h00, 1'b1,
                              out_item_t'{8'h00, 1'b1, 1'b0}));
    // zero sizes act as one
    dir_plan.push_back(mk_row(RowWrite, RegWidth,  32'd0, OpPixel, 8'h00, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowWrite, RegHeight, 32'd0, OpPixel, 8'h00, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowRead,  RegWidth,  32'd0, OpPixel, 8'h00, 1'b1, NoWant));
    dir_plan.push_back(mk_row(RowRead,  RegHeight, 32'd0, OpPixel, 8'h00, 1'b1, NoWant));
    dir_plan.push_back(mk_row(RowItem, RegWidth, '0, OpPixel, 8'h80, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowItem, RegWidth, '0, OpDrain, 8'hFF, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowItem, RegWidth, '0, OpDrain, 8'h00, 1'b1,
                              out_item_t'{8'h80, 1'b1, 1'b0}));
    // 2x2 frame with strong contrast
    dir_plan.push_back(mk_row(RowWrite, RegWidth,  32'd2, OpPixel, 8'h00, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowWrite, RegHeight, 32'd2, OpPixel, 8'h00, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowItem, RegWidth, '0, OpPixel, 8'h00, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowItem, RegWidth, '0, OpPixel, 8'hFF, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowItem, RegWidth, '0, OpPixel, 8'hFF, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowItem, RegWidth, '0, OpPixel, 8'h01, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowItem, RegWidth, '0, OpDrain, 8'h00, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowItem, RegWidth, '0, OpDrain, 8'h00, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowItem, RegWidth, '0, OpDrain, 8'h00, 1'b0, NoWant));
    // register write in mid frame restarts it
    dir_plan.push_back(mk_row(RowItem, RegWidth, '0, OpPixel, 8'h7E, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowItem, RegWidth, '0, OpPixel, 8'h81, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowWrite, RegHeight, 32'd1, OpPixel, 8'h00, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowItem, RegWidth, '0, OpPixel, 8'hFF, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowItem, RegWidth, '0, OpPixel, 8'h00, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowItem, RegWidth, '0, OpDrain, 8'h00, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowItem, RegWidth, '0, OpDrain, 8'h00, 1'b0, NoWant));
    dir_plan.push_back(mk_row(RowItem, RegWidth, '0, OpDrain, 8'h00, 1'b0, NoWant));

    foreach (dir_plan[i]) begin
      case (dir_plan[i].kind)
        RowWrite: cfg_write(dir_plan[i].regsel, dir_plan[i].value);
        RowRead:  cfg_read(dir_plan[i].regsel, dir_plan[i].value);
        default:  send_transfer(dir_plan[i].op, dir_plan[i].pixel, dir_plan[i].typed,
                                dir_plan[i].want);
      endcase
    end

    // random frames, mostly small
    sent = 0;
    while (sent < RandomItems) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          w_pick = $urandom_range(1, 6);
          h_pick = $urandom_range(1, 6);
        end
        6, 7, 8: begin
          w_pick = $urandom_range(7, 24);
          h_pick = $urandom_range(1, 4);
        end
        default: begin
          w_pick = $urandom_range(25, 64);
          h_pick = $urandom_range(1, 2);
        end
      endcase
      cfg_write(RegWidth, w_pick);
      cfg_write(RegHeight, h_pick);
      repeat ($urandom_range(1, 3)) begin
        style_pick = $urandom_range(0, 9);
        style = (style_pick < 6) ? FrameClean :
                (style_pick < 7) ? FrameFlat :
                (style_pick < 9) ? FrameNoise : FrameCut;
        stream_frame(style, sent);
      end
    end

    settle_block();
    if (blur_errors + reg_errors == 0) begin
      $display("** gaussian_blur_3x3_stream_unit: PASSED **");
    end else begin
      $display("** gaussian_blur_3x3_stream_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== gaussian_blur_3x3_stream_unit.f =====
+incdir+design
design/gblur_pkg.sv
design/gblur_stream_if.sv
design/gblur_queue.sv
design/gblur_front.sv
design/gblur_back.sv
design/gaussian_blur_3x3_stream_unit.sv
sim/gaussian_blur_3x3_stream_unit_test.sv
